FILE: hdl/cbspl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbspl_pkg
// Shared types and fixed constants of the cubic B-spline point evaluator.
// ----------------------------------------------------------------------------
package cbspl_pkg;

	localparam int INDEX_BITS = 6;
	localparam int COUNT_BITS = 7;
	localparam int GUARD_BITS = 4;
	localparam int NUM_BANKS  = 4;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_EVAL = 1'b1
	} cmd_t;

endpackage

FILE: hdl/cbspl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbspl_if
// Request and result channels of the cubic B-spline point evaluator.
// ----------------------------------------------------------------------------
interface cbspl_req_if #(
	parameter int COORD_BITS  = 16,
	parameter int T_FRAC_BITS = 16
) ();
	logic                          valid;
	logic                          ready;
	cbspl_pkg::cmd_t               command;
	logic [cbspl_pkg::INDEX_BITS-1:0] point_index;
	logic signed [COORD_BITS-1:0]  point_x;
	logic signed [COORD_BITS-1:0]  point_y;
	logic [T_FRAC_BITS:0]          param_t;

	modport source (output valid, command, point_index, point_x, point_y, param_t,
		input ready);
	modport sink (input valid, command, point_index, point_x, point_y, param_t,
		output ready);
endinterface

interface cbspl_res_if #(
	parameter int COORD_BITS = 16
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] curve_x;
	logic signed [COORD_BITS-1:0] curve_y;
	logic                         was_clamped;

	modport source (output valid, curve_x, curve_y, was_clamped, input ready);
	modport sink (input valid, curve_x, curve_y, was_clamped, output ready);
endinterface

FILE: hdl/cbspl_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbspl_bank
// One bank of control point storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cbspl_bank #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: hdl/cubic_bspline_point_eval_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bspline_point_eval_core
// Uniform cubic B-spline evaluator using de Boor's scheme in fixed point.
// ----------------------------------------------------------------------------
// The block accepts one request every cycle while the result side does not
// stall, loads and evaluations alike, and presents each evaluated point on the
// registered result channel. Control points live in four memory banks
// interleaved by the low two bits of the point index, so the four neighbouring
// points of a span are fetched in one parallel read; the three de Boor levels
// then run as a pipeline of multiply, divide-by-reciprocal and add stages. A
// load is written to its bank from stage 1, before any later evaluation reads
// the banks. point_count must only be written while no request is in flight.
module cubic_bspline_point_eval_core #(
	parameter int MAX_POINTS  = 64,
	parameter int COORD_BITS  = 16,
	parameter int T_FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [cbspl_pkg::COUNT_BITS-1:0]   cfg_wdata,
	cbspl_req_if.sink                          req,
	cbspl_res_if.source                        res
);
	import cbspl_pkg::*;

	localparam int F     = T_FRAC_BITS;
	localparam int TW    = F + 1;
	localparam int CW    = $clog2(MAX_POINTS + 1);
	localparam int MW    = $clog2(MAX_POINTS + 8);
	localparam int UW    = TW + MW;
	localparam int PWR   = $clog2(MAX_POINTS);
	localparam int PW    = (PWR < 2) ? 2 : PWR;
	localparam int BD    = (MAX_POINTS + 3) / 4;
	localparam int AWR   = PW - 2;
	localparam int AW    = (AWR < 1) ? 1 : AWR;
	localparam int SW    = MW + 2;
	localparam int DW    = COORD_BITS + GUARD_BITS;
	localparam int NUMW  = F + 2;
	localparam int PRW   = F + DW + 3;
	localparam int YW    = DW + 4;
	localparam int NW    = YW + 1;
	localparam int S3    = NW + 1;
	localparam logic [NW-1:0] RECIP3 = NW'((64'd1 << S3) / 64'd3);
	localparam logic [NW:0]   OFF3   = (NW+1)'(64'd3 << (YW - 1));
	localparam logic [NW:0]   BIAS3  = (NW+1)'(64'd1 << (YW - 1));

	logic adv;
	logic [COUNT_BITS-1:0] point_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= COUNT_BITS'(2);
		end else if (cfg_we) begin
			point_count_q <= cfg_wdata;
		end
	end

	assign adv       = !res.valid || res.ready;
	assign req.ready = adv;

	// Stage 0: count clamp and t*m.
	logic [CW-1:0] c0;
	logic [MW-1:0] m0;
	logic [UW-1:0] u0;

	always_comb begin
		if (point_count_q < COUNT_BITS'(2)) begin
			c0 = CW'(2);
		end else if (int'(point_count_q) > MAX_POINTS) begin
			c0 = CW'(MAX_POINTS);
		end else begin
			c0 = CW'(point_count_q);
		end
		m0 = MW'(c0) + MW'(7);
		u0 = UW'(req.param_t) * UW'(m0);
	end

	logic                     v_s1;
	cmd_t                     cmd_s1;
	logic [INDEX_BITS-1:0]    idx_s1;
	logic [2*COORD_BITS-1:0]  wpt_s1;
	logic [CW-1:0]            c_s1;
	logic [MW-1:0]            m_s1;
	logic [UW-1:0]            u_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= req.command;
			idx_s1 <= req.point_index;
			wpt_s1 <= {req.point_x, req.point_y};
			c_s1   <= c0;
			m_s1   <= m0;
			u_s1   <= u0;
		end
	end

	// Stage 1: clamp, span, bank addresses, bank writes.
	logic [UW-1:0]   u_c;
	logic            clamp_1;
	logic [MW-1:0]   l_1;
	logic [F:0]      frac_1;
	logic [PW-1:0]   raw_1 [4];
	logic [AW-1:0]   raddr [NUM_BANKS];
	logic [NUM_BANKS-1:0] bank_we;
	logic [AW-1:0]   waddr;
	logic [2*COORD_BITS-1:0] rdata [NUM_BANKS];

	always_comb begin
		logic [UW-1:0]        lo_u;
		logic [UW-1:0]        hi_u;
		logic signed [SW-1:0] s;
		lo_u    = UW'(3) << F;
		hi_u    = UW'(m_s1 - MW'(3)) << F;
		u_c     = u_s1;
		clamp_1 = 1'b0;
		if (u_s1 < lo_u) begin
			u_c     = lo_u;
			clamp_1 = 1'b1;
		end
		if (u_s1 > hi_u) begin
			u_c     = hi_u;
			clamp_1 = 1'b1;
		end
		l_1 = MW'(u_c >> F);
		if (l_1 > m_s1 - MW'(4)) begin
			l_1 = m_s1 - MW'(4);
		end
		frac_1 = (F+1)'(u_c - (UW'(l_1) << F));
		for (int j = 0; j < 4; j++) begin
			s = $signed({2'b00, l_1}) - SW'(5) + SW'(j);
			if (s < 0) begin
				raw_1[j] = '0;
			end else if (s > $signed(SW'(c_s1) - SW'(1))) begin
				raw_1[j] = PW'(c_s1 - CW'(1));
			end else begin
				raw_1[j] = PW'(s);
			end
		end
		for (int k = 0; k < NUM_BANKS; k++) begin
			raddr[k] = '0;
			for (int j = 3; j >= 0; j--) begin
				if (raw_1[j][1:0] == 2'(k)) begin
					raddr[k] = AW'(raw_1[j] >> 2);
				end
			end
		end
		waddr = AW'(idx_s1 >> 2);
		for (int k = 0; k < NUM_BANKS; k++) begin
			bank_we[k] = v_s1 && adv && (cmd_s1 == CMD_LOAD)
				&& (int'(idx_s1) < MAX_POINTS) && (idx_s1[1:0] == 2'(k));
		end
	end

	for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
		cbspl_bank #(
			.DEPTH  (BD),
			.ADDR_W (AW),
			.DATA_W (2*COORD_BITS)
		) u_bank (
			.clk   (clk),
			.we    (bank_we[k]),
			.waddr (waddr),
			.wdata (wpt_s1),
			.re    (adv),
			.raddr (raddr[k]),
			.rdata (rdata[k])
		);
	end

	logic [9:2] v_q;
	logic [F:0] frac_q [9:2];
	logic       clamp_q [9:2];
	logic [1:0] sel_s2 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[8:2], v_s1 && (cmd_s1 == CMD_EVAL)};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frac_q[2]  <= frac_1;
			clamp_q[2] <= clamp_1;
			for (int i = 3; i <= 9; i++) begin
				frac_q[i]  <= frac_q[i-1];
				clamp_q[i] <= clamp_q[i-1];
			end
			for (int j = 0; j < 4; j++) begin
				sel_s2[j] <= raw_1[j][1:0];
			end
		end
	end

	// Both axes run the same datapath; axis 0 is x, axis 1 is y.
	logic signed [DW-1:0]  d_s3  [2][4];
	logic signed [PRW-1:0] p_s4  [2][4];
	logic signed [DW-1:0]  lo_s4 [2][4];
	logic [NW-1:0]         n_s5  [2][4];
	logic [NW-1:0]         q_s5  [2][4];
	logic signed [DW-1:0]  lo_s5 [2][4];
	logic signed [DW-1:0]  a_s6  [2][4];
	logic signed [PRW-1:0] p_s7  [2][4];
	logic signed [DW-1:0]  lo_s7 [2][4];
	logic signed [DW-1:0]  b_s8  [2][4];
	logic signed [PRW-1:0] p_s9  [2];
	logic signed [DW-1:0]  lo_s9 [2];
	logic signed [COORD_BITS-1:0] out_d [2];

	function automatic logic signed [PRW-1:0] mul_num(
		input logic [F:0] frac, input int ofs,
		input logic signed [DW-1:0] hi, input logic signed [DW-1:0] lo);
		logic [NUMW-1:0]            num;
		logic signed [DW:0]         diff;
		logic signed [F+DW+3:0]     prod;
		num  = NUMW'(frac) + (NUMW'(ofs) << F);
		diff = $signed({hi[DW-1], hi}) - $signed({lo[DW-1], lo});
		prod = $signed({1'b0, num}) * diff;
		return PRW'(prod);
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 2; a++) begin
				for (int j = 0; j < 4; j++) begin
					logic [2*COORD_BITS-1:0] w;
					w = rdata[sel_s2[j]];
					if (a == 0) begin
						d_s3[a][j] <= $signed(DW'($signed(w[2*COORD_BITS-1:COORD_BITS])))
							<<< GUARD_BITS;
					end else begin
						d_s3[a][j] <= $signed(DW'($signed(w[COORD_BITS-1:0])))
							<<< GUARD_BITS;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 2; a++) begin
				for (int j = 1; j < 4; j++) begin
					logic signed [PRW:0]  sum;
					logic signed [YW-1:0] y;
					logic [NW:0]          nn;
					logic [2*NW-1:0]      prod;
					logic [NW-1:0]        r;
					logic [NW-1:0]        q;
					logic signed [NW:0]   quot;
					logic signed [PRW:0]  sum2;
					// Level one: divide by three times one.
					p_s4[a][j]  <= mul_num(frac_q[3], 3 - j, d_s3[a][j], d_s3[a][j-1]);
					lo_s4[a][j] <= d_s3[a][j-1];
					sum  = $signed({p_s4[a][j][PRW-1], p_s4[a][j]})
						+ $signed((PRW+1)'(64'd3 << (F - 1)));
					y    = YW'(sum >>> F);
					nn   = (NW+1)'($signed({y[YW-1], y})) + OFF3;
					prod = nn[NW-1:0] * RECIP3;
					n_s5[a][j]  <= nn[NW-1:0];
					q_s5[a][j]  <= NW'(prod >> S3);
					lo_s5[a][j] <= lo_s4[a][j];
					r    = n_s5[a][j] - (q_s5[a][j] << 1) - q_s5[a][j];
					q    = q_s5[a][j] + ((r >= NW'(3)) ? NW'(1) : NW'(0));
					quot = $signed({1'b0, q}) - $signed(BIAS3);
					a_s6[a][j] <= DW'(quot + (NW+1)'(lo_s5[a][j]));
					// Level two: divide by two.
					if (j >= 2) begin
						p_s7[a][j]  <= mul_num(frac_q[6], 3 - j, a_s6[a][j], a_s6[a][j-1]);
						lo_s7[a][j] <= a_s6[a][j-1];
						sum2 = $signed({p_s7[a][j][PRW-1], p_s7[a][j]})
							+ $signed((PRW+1)'(64'd1 << F));
						b_s8[a][j] <= DW'((sum2 >>> (F + 1)) + (PRW+1)'(lo_s7[a][j]));
					end
				end
				// Level three: divide by one.
				p_s9[a]  <= mul_num(frac_q[8], 0, b_s8[a][3], b_s8[a][2]);
				lo_s9[a] <= b_s8[a][2];
			end
		end
	end

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			logic signed [PRW:0] sum;
			logic signed [DW:0]  d;
			logic signed [DW:0]  r;
			sum = $signed({p_s9[a][PRW-1], p_s9[a]})
				+ $signed((PRW+1)'(64'd1 << (F - 1)));
			d   = (DW+1)'((sum >>> F) + (PRW+1)'(lo_s9[a]));
			r   = (d + (DW+1)'(1 << (GUARD_BITS - 1))) >>> GUARD_BITS;
			if (r > $signed((DW+1)'((64'd1 << (COORD_BITS - 1)) - 1))) begin
				out_d[a] = {1'b0, {(COORD_BITS-1){1'b1}}};
			end else if (r < -$signed((DW+1)'(64'd1 << (COORD_BITS - 1)))) begin
				out_d[a] = {1'b1, {(COORD_BITS-1){1'b0}}};
			end else begin
				out_d[a] = COORD_BITS'(r);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (adv) begin
			res.valid <= v_q[9];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res.curve_x     <= out_d[0];
			res.curve_y     <= out_d[1];
			res.was_clamped <= clamp_q[9];
		end
	end
endmodule
